/* rtl/wtk_pkg.sv */
// types and constants shared by the windowed timekeeper files
package wtk_pkg;

	localparam int STORE_BYTES = 2048;
	localparam int STORE_AW    = $clog2(STORE_BYTES);
	localparam int OFFSET_W    = 7;
	localparam int CLOCK_REGS  = 8;

	localparam logic [15:0] PORT_MASK   = 16'hfff8;
	localparam logic [15:0] WINDOW_MASK = 16'hfff0;

	// top eight bytes of the store are the clock registers
	localparam logic [STORE_AW-1:0] CLOCK_BASE = STORE_AW'(STORE_BYTES - CLOCK_REGS);

	// clock register positions within the top eight bytes
	localparam logic [2:0] CLK_CONTROL = 3'd0;
	localparam logic [2:0] CLK_SECOND  = 3'd1;
	localparam logic [2:0] CLK_MINUTE  = 3'd2;
	localparam logic [2:0] CLK_HOUR    = 3'd3;
	localparam logic [2:0] CLK_WEEKDAY = 3'd4;
	localparam logic [2:0] CLK_DAY     = 3'd5;
	localparam logic [2:0] CLK_MONTH   = 3'd6;
	localparam logic [2:0] CLK_YEAR    = 3'd7;

	localparam int          STOP_BIT      = 7;
	localparam int          FTEST_BIT     = 6;
	localparam logic [7:0]  SECOND_RESET  = 8'h80;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic {
		REG_WINDOW_PORT = 1'b0,
		REG_DATA_WINDOW = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t         opcode;
		logic [15:0] bus_address;
		logic [15:0] bus_data;
		logic [6:0]  now_year;
		logic [3:0]  now_month;
		logic [4:0]  now_day;
		logic [2:0]  now_weekday;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [5:0]  now_second;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       claimed;
	} rsp_t;

	typedef struct packed {
		reg_idx_t    index;
		logic [15:0] value;
	} cfg_t;

	// binary value reduced modulo 100, as two bcd digits
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [6:0] r;
		logic [3:0] tens;
		logic [6:0] ones;
		r = (v >= 7'd100) ? v - 7'd100 : v;
		tens = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (r >= 7'(10 * k)) tens = 4'(k);
		end
		ones = r - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
		return {tens, ones[3:0]};
	endfunction

endpackage

/* rtl/wtk_stream_if.sv */
// valid/ready channel carrying one payload item
interface wtk_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/wtk_ram.sv */
// generic single write port ram with registered read
module wtk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

/* rtl/windowed_timekeeper_nvram.sv */
// top level of the windowed timekeeper nvram
//
// a 2048-byte battery-backed store whose top eight bytes are clock registers,
// reached through a 16-byte bus window; a write to the window port moves the window
// channels: req (sink) takes one bus access per item, rsp (source) gives one
// result item per access, cfg (sink, always ready) writes the two decoder addresses
// path: an item is caught in the input register when it is accepted and moves to
// the result register once that is free, and shows on rsp from there;
// throughput is one item per cycle while rsp keeps taking results, with the single
// store port serving either the read or the write of each access
// reset: the clock registers live in flops and reset at once, with the oscillator
// stopped; the store ram is swept to zero one byte a cycle while req.ready stays
// low; cfg writes are taken during the sweep
// stall: when rsp is not taken the result register holds, the input register fills,
// and then req.ready drops until rsp moves again
module windowed_timekeeper_nvram
	import wtk_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	wtk_stream_if.sink   req,
	wtk_stream_if.source rsp,
	wtk_stream_if.sink   cfg
);

	// decoder addresses and window
	logic [15:0]         port_addr_q;
	logic [15:0]         window_addr_q;
	logic [OFFSET_W-1:0] window_offset_q;

	// clock registers, kept in flops so stop and test bits are always visible
	logic [7:0] clock_q [CLOCK_REGS];

	// reset sweep of the ram
	logic                clr_busy_q;
	logic [STORE_AW-1:0] clr_addr_q;

	// input register
	logic valid_s1;
	req_t req_s1;

	// result register
	logic       valid_s2;
	logic       claimed_s2;
	logic [7:0] rd_s2;
	logic       ram_sel_s2;

	logic                advance;
	logic [STORE_AW-1:0] byte_addr;
	logic                is_write;
	logic                port_hit;
	logic                in_window;
	logic                clock_hit;
	logic [2:0]          clk_idx;
	logic [7:0]          stored;
	logic [7:0]          clock_rd;
	logic                claimed;
	logic                ram_we;
	logic                ram_re;
	logic [STORE_AW-1:0] ram_waddr;
	logic [7:0]          ram_wdata;
	logic [7:0]          ram_rdata;

	assign cfg.ready = 1'b1;

	// the item in the input register moves on when the result register is free
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !clr_busy_q && (!valid_s1 || advance);

	// address decode of the item in the input register
	assign is_write  = (req_s1.opcode == OP_WRITE);
	assign byte_addr = {window_offset_q, req_s1.bus_address[3:0]};
	assign port_hit  = is_write && ((req_s1.bus_address & PORT_MASK) == port_addr_q);
	assign in_window = (req_s1.bus_address & WINDOW_MASK) == window_addr_q;
	assign clock_hit = byte_addr[STORE_AW-1:3] == CLOCK_BASE[STORE_AW-1:3];
	assign clk_idx   = byte_addr[2:0];
	assign stored    = clock_q[clk_idx];
	assign claimed   = port_hit || in_window;

	// clock read: live bcd time unless the stop bit freezes it (seconds and control excepted) or frequency test is on
	always_comb begin
		clock_rd = stored;
		if ((clk_idx != CLK_SECOND) && (clk_idx != CLK_CONTROL)
				&& clock_q[CLK_SECOND][STOP_BIT]) begin
			clock_rd = stored;
		end else if (clock_q[CLK_WEEKDAY][FTEST_BIT]) begin
			clock_rd = stored;
		end else begin
			case (clk_idx)
				CLK_YEAR:    clock_rd = to_bcd(req_s1.now_year);
				CLK_MONTH:   clock_rd = to_bcd({3'b000, req_s1.now_month});
				CLK_DAY:     clock_rd = to_bcd({2'b00, req_s1.now_day});
				CLK_WEEKDAY: clock_rd = {stored[7:4], 4'(req_s1.now_weekday) + 4'd1};
				CLK_HOUR:    clock_rd = to_bcd({2'b00, req_s1.now_hour});
				CLK_MINUTE:  clock_rd = to_bcd({1'b0, req_s1.now_minute});
				CLK_SECOND:  clock_rd = {stored[STOP_BIT],
					7'(to_bcd({1'b0, req_s1.now_second}))};
				default:     clock_rd = stored;
			endcase
		end
	end

	// store port: sweep writes zeros after reset, then at most one access per item
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = byte_addr;
		ram_wdata = req_s1.bus_data[7:0];
		if (clr_busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 8'h00;
		end else if (advance && is_write && !port_hit && in_window && !clock_hit) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = advance && !is_write && in_window && !clock_hit;

	wtk_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(byte_addr),
		.rdata(ram_rdata)
	);

	// control state, decoder registers and clock registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_addr_q     <= 16'd8;
			window_addr_q   <= 16'd16;
			window_offset_q <= '0;
			for (int i = 0; i < CLOCK_REGS; i++)
				clock_q[i] <= (3'(i) == CLK_SECOND) ? SECOND_RESET : 8'h00;
			clr_busy_q      <= 1'b1;
			clr_addr_q      <= '0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.data.index)
					REG_WINDOW_PORT: port_addr_q   <= cfg.data.value;
					REG_DATA_WINDOW: window_addr_q <= cfg.data.value;
				endcase
			end

			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + STORE_AW'(1);
				if (clr_addr_q == '1) clr_busy_q <= 1'b0;
			end

			// side effects of an item happen as it leaves the input register
			if (advance && is_write) begin
				if (port_hit) begin
					window_offset_q <= req_s1.bus_data[OFFSET_W-1:0];
				end else if (in_window && clock_hit) begin
					clock_q[clk_idx] <= req_s1.bus_data[7:0];
				end
			end

			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) req_s1 <= req.data;
		if (advance) begin
			claimed_s2 <= claimed;
			ram_sel_s2 <= ram_re;
			rd_s2      <= (!is_write && in_window && clock_hit) ? clock_rd : 8'h00;
		end
	end

	// ram data stays put while the result waits since reads only fire on advance
	assign rsp.valid          = valid_s2;
	assign rsp.data.claimed   = claimed_s2;
	assign rsp.data.read_data = ram_sel_s2 ? ram_rdata : rd_s2;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the windowed timekeeper nvram: directed, decoder, stall and random tests
module tb_top
	import wtk_pkg::*;
;

	// generous cycle limit: reset sweep, worst gaps and stalls on every item, the long hold
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN    = 150;

	logic clk;
	logic arst_n;

	wtk_stream_if #(.payload_t(req_t)) req ();
	wtk_stream_if #(.payload_t(rsp_t)) rsp ();
	wtk_stream_if #(.payload_t(cfg_t)) cfg ();

	windowed_timekeeper_nvram dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// shadow copy of the block state, updated in acceptance order
	logic [7:0]          nv_mem [STORE_BYTES];
	logic [OFFSET_W-1:0] win_offset;
	logic [15:0]         port_base;
	logic [15:0]         win_base;

	// results still owed by the block, oldest first
	rsp_t due_responses [$];

	int  err_count;
	int  cycle_count;
	int  hold_cycles;
	bit  src_idle;
	bit  sink_idle;

	// clock and the single reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// binary to two bcd digits, reduced modulo 100
	function automatic logic [7:0] bcd2(input int v);
		int r;
		r = v % 100;
		return {4'(r / 10), 4'(r % 10)};
	endfunction

	// what a read of clock register k returns, given the stored stop and test bits
	function automatic logic [7:0] clock_byte(input logic [2:0] k, input req_t it);
		logic [7:0] stored;
		stored = nv_mem[CLOCK_BASE | 11'(k)];
		// stopped oscillator freezes everything but seconds and control
		if (k != CLK_SECOND && k != CLK_CONTROL && nv_mem[CLOCK_BASE | 11'(CLK_SECOND)][STOP_BIT])
			return stored;
		// frequency test shows the stored bytes for every clock register
		if (nv_mem[CLOCK_BASE | 11'(CLK_WEEKDAY)][FTEST_BIT])
			return stored;
		case (k)
			CLK_YEAR:    return bcd2(it.now_year);
			CLK_MONTH:   return bcd2(it.now_month);
			CLK_DAY:     return bcd2(it.now_day);
			CLK_WEEKDAY: return {stored[7:4], 4'(it.now_weekday) + 4'd1};
			CLK_HOUR:    return bcd2(it.now_hour);
			CLK_MINUTE:  return bcd2(it.now_minute);
			CLK_SECOND:  return {stored[7], 7'h00} | bcd2(it.now_second);
			default:     return stored;
		endcase
	endfunction

	// apply one bus access to the shadow state and give the result it must produce
	function automatic rsp_t timekeeper_predict(input req_t it);
		logic [STORE_AW-1:0] a;
		logic                in_win;
		rsp_t                r;
		a = {win_offset, it.bus_address[3:0]};
		in_win = (it.bus_address & WINDOW_MASK) == win_base;
		r = '0;
		if (it.opcode == OP_WRITE) begin
			// the port wins over the window when both decode
			if ((it.bus_address & PORT_MASK) == port_base) begin
				win_offset = it.bus_data[OFFSET_W-1:0];
				r.claimed = 1'b1;
			end else if (in_win) begin
				nv_mem[a] = it.bus_data[7:0];
				r.claimed = 1'b1;
			end
		end else if (in_win) begin
			// reads never decode the port
			r.read_data = (a >= CLOCK_BASE) ? clock_byte(a[2:0], it) : nv_mem[a];
			r.claimed = 1'b1;
		end
		return r;
	endfunction

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// access with the time fields all zeros or all ones
	function automatic req_t fixed_access(input op_t op, input logic [15:0] addr,
			input logic [15:0] data, input bit ones);
		req_t it;
		it = ones ? '1 : '0;
		it.opcode = op;
		it.bus_address = addr;
		it.bus_data = data;
		return it;
	endfunction

	// fill the time fields, mostly in calendar range, sometimes any bit pattern
	function automatic req_t with_random_time(input req_t it);
		if ($urandom_range(0, 3) == 0) begin
			it.now_year    = 7'($urandom);
			it.now_month   = 4'($urandom);
			it.now_day     = 5'($urandom);
			it.now_weekday = 3'($urandom);
			it.now_hour    = 5'($urandom);
			it.now_minute  = 6'($urandom);
			it.now_second  = 6'($urandom);
		end else begin
			it.now_year    = 7'($urandom_range(0, 99));
			it.now_month   = 4'($urandom_range(1, 12));
			it.now_day     = 5'($urandom_range(1, 31));
			it.now_weekday = 3'($urandom_range(0, 6));
			it.now_hour    = 5'($urandom_range(0, 23));
			it.now_minute  = 6'($urandom_range(0, 59));
			it.now_second  = 6'($urandom_range(0, 60));
		end
		return it;
	endfunction

	// random access aimed mostly at the current port and window
	function automatic req_t random_access();
		req_t it;
		int   r;
		it = '0;
		it.bus_data = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 45) begin
			// window access; writes often keep the stop and test bits clear
			it.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			it.bus_address = (win_base & WINDOW_MASK) | 16'($urandom_range(0, 15));
			if ($urandom_range(0, 1))
				it.bus_data[7:6] = 2'b00;
		end else if (r < 65) begin
			// window move, often to the clock page
			it.opcode = OP_WRITE;
			it.bus_address = (port_base & PORT_MASK) | 16'($urandom_range(0, 7));
			if ($urandom_range(0, 9) < 4)
				it.bus_data[6:0] = 7'h7f;
		end else if (r < 72) begin
			it.opcode = OP_READ;
			it.bus_address = (port_base & PORT_MASK) | 16'($urandom_range(0, 7));
		end else begin
			it.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			it.bus_address = 16'($urandom);
		end
		return with_random_time(it);
	endfunction

	// send one item; the gap comes first so valid never drops and rises in one step
	task automatic send_access(input req_t it);
		int g;
		g = src_idle ? pick_gap() : 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req.data  <= it;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		due_responses.push_back(timekeeper_predict(it));
	endtask

	// stop offering and wait until every owed result is back
	task automatic drain();
		req.valid <= 1'b0;
		while (due_responses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// decoder register write, only with the block idle
	task automatic write_decoder(input reg_idx_t idx, input logic [15:0] val);
		drain();
		cfg.data  <= '{index: idx, value: val};
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_WINDOW_PORT)
			port_base = val;
		else
			win_base = val;
	endtask

	// receiver: random stalls, or one long hold when a test asks for it
	initial begin : rsp_side
		int n;
		rsp.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				rsp.ready <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 3) == 0) begin
				n = pick_gap();
				if (n == 0)
					n = 1;
				rsp.ready <= 1'b0;
			end else begin
				n = $urandom_range(1, 6);
				rsp.ready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	// result check against the oldest owed result
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (due_responses.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result read_data=%h claimed=%b", $time,
					rsp.data.read_data, rsp.data.claimed);
			end else begin
				want = due_responses.pop_front();
				if (rsp.data.read_data !== want.read_data) begin
					err_count++;
					$display("%0t: read_data expected %h actual %h", $time,
						want.read_data, rsp.data.read_data);
				end
				if (rsp.data.claimed !== want.claimed) begin
					err_count++;
					$display("%0t: claimed expected %b actual %b", $time,
						want.claimed, rsp.data.claimed);
				end
			end
		end
	end

	// reset decoders: port at 0x08, window at 0x10, offset 0
	task automatic test_directed_access();
		int k;
		send_access(fixed_access(OP_READ,  16'h0010, 16'h0000, 1'b0));  // byte 0, never written
		send_access(fixed_access(OP_READ,  16'h0008, 16'hffff, 1'b1));  // read of the port
		send_access(fixed_access(OP_WRITE, 16'h000c, 16'hff7f, 1'b1));  // window to clock page
		send_access(fixed_access(OP_READ,  16'h0019, 16'h0000, 1'b0));  // seconds while stopped
		send_access(fixed_access(OP_READ,  16'h001a, 16'h0000, 1'b1));  // minutes while stopped
		send_access(fixed_access(OP_WRITE, 16'h0019, 16'h5a00, 1'b0));  // start the oscillator
		// every clock register with out-of-range time values
		for (k = 0; k < CLOCK_REGS; k++)
			send_access(fixed_access(OP_READ, 16'h0018 | 16'(k), 16'h0000, 1'b1));
		send_access(fixed_access(OP_WRITE, 16'h001b, 16'h0023, 1'b0));  // hour write is stored
		send_access(fixed_access(OP_READ,  16'h001b, 16'h0000, 1'b0));  // but reads live time
		send_access(fixed_access(OP_WRITE, 16'h001c, 16'h0040, 1'b1));  // frequency test on
		send_access(fixed_access(OP_READ,  16'h001b, 16'h0000, 1'b1));
		send_access(fixed_access(OP_READ,  16'h001c, 16'h0000, 1'b1));
		send_access(fixed_access(OP_WRITE, 16'h001c, 16'h00b0, 1'b0));  // test off, high nibble set
		send_access(fixed_access(OP_READ,  16'h001c, 16'h0000, 1'b1));  // weekday 7 reads as 8
		send_access(fixed_access(OP_WRITE, 16'hffff, 16'hffff, 1'b1));  // nobody claims
		send_access(fixed_access(OP_WRITE, 16'h0008, 16'h0000, 1'b0));  // window back to offset 0
		send_access(fixed_access(OP_WRITE, 16'h001f, 16'hffff, 1'b1));
		send_access(fixed_access(OP_READ,  16'h001f, 16'h0000, 1'b0));
	endtask

	// overlapping, top-of-map and misaligned decoder settings
	task automatic test_decoder_settings();
		logic [15:0] ports [4];
		logic [15:0] wins [4];
		int          s;
		ports = '{16'h0000, 16'hfff8, 16'h0013, 16'h0008};
		wins  = '{16'h0000, 16'hfff0, 16'h0027, 16'h0010};
		for (s = 0; s < 4; s++) begin
			write_decoder(REG_WINDOW_PORT, ports[s]);
			write_decoder(REG_DATA_WINDOW, wins[s]);
			send_access(with_random_time(fixed_access(OP_WRITE, ports[s], 16'h007f, 1'b0)));
			send_access(with_random_time(fixed_access(OP_READ, ports[s], 16'h0000, 1'b0)));
			send_access(with_random_time(fixed_access(OP_WRITE, wins[s] | 16'h000b,
				16'($urandom), 1'b0)));
			send_access(with_random_time(fixed_access(OP_READ, wins[s] | 16'h000b,
				16'h0000, 1'b0)));
			send_access(with_random_time(fixed_access(OP_WRITE, wins[s] | 16'h0004,
				16'h00ff, 1'b0)));
			send_access(with_random_time(fixed_access(OP_READ, wins[s] | 16'h0004,
				16'h0000, 1'b0)));
			send_access(random_access());
			send_access(random_access());
		end
	endtask

	// long receiver hold while items keep coming, so the input side backs up
	task automatic test_backpressure();
		src_idle = 1'b0;
		drain();
		hold_cycles = HOLD_LEN;
		while (hold_cycles != 0)
			@(posedge clk);
		repeat (40) send_access(random_access());
	endtask

	// random phases, each with its own decoder setting and idling mix
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [15:0] pv;
		logic [15:0] wv;
		int          p;
		for (p = 0; p < phases; p++) begin
			pv = 16'($urandom) & PORT_MASK;
			wv = 16'($urandom) & WINDOW_MASK;
			// now and then a misaligned base that can never decode
			if ($urandom_range(0, 5) == 0)
				pv = 16'($urandom);
			if ($urandom_range(0, 5) == 0)
				wv = 16'($urandom);
			// last phase back at the reset map
			if (p == phases - 1) begin
				pv = 16'h0008;
				wv = 16'h0010;
			end
			write_decoder(REG_WINDOW_PORT, pv);
			write_decoder(REG_DATA_WINDOW, wv);
			src_idle  = (p % 3) != 1;
			sink_idle = (p % 3) != 1;
			repeat (per_phase) send_access(random_access());
		end
	endtask

	// main sequence
	initial begin
		int k;
		for (k = 0; k < STORE_BYTES; k++)
			nv_mem[k] = 8'h00;
		nv_mem[CLOCK_BASE | 11'(CLK_SECOND)] = SECOND_RESET;
		win_offset  = '0;
		port_base   = 16'h0008;
		win_base    = 16'h0010;
		err_count   = 0;
		cycle_count = 0;
		hold_cycles = 0;
		src_idle    = 1'b1;
		sink_idle   = 1'b1;
		req.valid   = 1'b0;
		req.data    = '0;
		cfg.valid   = 1'b0;
		cfg.data    = '0;
		arst_n      = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_access();
		test_decoder_settings();
		test_backpressure();
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		test_random_traffic(6, 290);

		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
